@@ hdl/plist_pkg.sv @@
// Shared types and constants for the positional list engine.
package plist_pkg;

   localparam int DEF_CAPACITY = 64;
   localparam int VALUE_W      = 32;
   localparam int MODE_W       = 3;
   localparam int POS_W        = 7;
   localparam int STATUS_W     = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_INSERT = 3'd0,
      MODE_DELETE = 3'd1,
      MODE_SEARCH = 3'd2,
      MODE_READ   = 3'd3,
      MODE_CLEAR  = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK       = 3'd0,
      STAT_FULL     = 3'd1,
      STAT_EMPTY    = 3'd2,
      STAT_BADPOS   = 3'd3,
      STAT_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_TREE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic ins;
      logic del;
      logic search;
   } cell_cmd_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] value;
   } node_type;

endpackage

@@ hdl/plist_cell.sv @@
// One list entry: shifts with its neighbors and flags a search or read hit.
module plist_cell
   import plist_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic [IDX_W-1:0]          k,
   input  logic [CNT_W-1:0]          fill,
   input  logic signed [VALUE_W-1:0] key,
   input  logic signed [VALUE_W-1:0] new_value,
   input  logic signed [VALUE_W-1:0] left_value,
   input  logic signed [VALUE_W-1:0] right_value,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      hit
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      live;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (MY_IDX == k) begin
            entry_in = new_value;
         end else if (MY_IDX > k) begin
            entry_in = left_value;
         end
      end else if (cmd.del) begin
         if (MY_IDX >= k) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign live  = MY_CNT < fill;
   assign hit   = live && (cmd.search ? (entry_ff == key) : (MY_IDX == k));
   assign entry = entry_ff;

endmodule

@@ hdl/plist_merge.sv @@
// Registered node of the first-hit tree: the left child wins.
module plist_merge
   import plist_pkg::*;
#(
   parameter int IDX_W = 6
) (
   input  logic             clock,
   input  node_type         left_node,
   input  logic [IDX_W-1:0] left_idx,
   input  node_type         right_node,
   input  logic [IDX_W-1:0] right_idx,
   output node_type         out_node,
   output logic [IDX_W-1:0] out_idx
);

   node_type         node_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      node_ff <= left_node.hit ? left_node : right_node;
      idx_ff  <= left_node.hit ? left_idx : right_idx;
   end

   assign out_node = node_ff;
   assign out_idx  = idx_ff;

endmodule

@@ hdl/positional_list_engine.sv @@
// Positional list engine: ordered list of signed entries held in a row of cells.
// Insert, delete, clear and every rejected operation take effect at the transfer
// and answer in the next cycle, so they can run one per cycle while the output is
// not stalled. Search and read go through a registered first-hit tree over the
// cells: the walk is set by the tree depth, and the engine stalls new requests
// until the result is loaded, so a search or read is through before the next
// transfer is taken.
// No clearing pass: the list is empty right after reset.
module positional_list_engine
   import plist_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_found_position,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [POS_W-1:0]           rsp_entry_count
);

   localparam int TREE_DEPTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEAVES     = 1 << TREE_DEPTH;
   localparam int IDX_W      = TREE_DEPTH;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int EXT_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int TCNT_W     = $clog2(TREE_DEPTH + 1);
   localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [TCNT_W-1:0] DEPTH_CNT = TCNT_W'(TREE_DEPTH);
   localparam logic [TCNT_W-1:0] ONE_CNT = TCNT_W'(1);

   state_type state_ff, state_in;
   logic [TCNT_W-1:0] tcnt_ff, tcnt_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;

   logic                      op_search_ff;
   logic [IDX_W-1:0]          op_k_ff;
   logic signed [VALUE_W-1:0] op_value_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                status_ff, status_in;
   logic [POS_W-1:0]          found_ff, found_in;
   logic signed [VALUE_W-1:0] read_ff, read_in;
   logic [POS_W-1:0]          count_ff, count_in;

   logic       accept, rsp_free, load_imm, load_tree, needs_tree;
   logic       full, empty, pos_zero, ins_ok, rd_ok;
   logic [EXT_W-1:0] fill_ext, pos_ext;
   logic [IDX_W-1:0] req_k, cell_k;
   mode_type   mode;
   status_type imm_status;
   logic [CNT_W-1:0] imm_fill;
   cell_cmd_type cmd;

   node_type         nd   [2*LEAVES-1];
   logic [IDX_W-1:0] nidx [2*LEAVES-1];
   logic signed [VALUE_W-1:0] ent [CAPACITY];
   logic [IDX_W:0]   root_pos;

   // request decode
   assign mode     = mode_type'(req_mode);
   assign fill_ext = EXT_W'(fill_ff);
   assign pos_ext  = EXT_W'(req_position);
   assign full     = fill_ff == CAP_CNT;
   assign empty    = fill_ff == '0;
   assign pos_zero = req_position == '0;
   assign ins_ok   = !full && !pos_zero && (pos_ext <= fill_ext + EXT_W'(1));
   assign rd_ok    = !empty && !pos_zero && (pos_ext <= fill_ext);
   assign req_k    = IDX_W'(req_position - POS_W'(1));

   always_comb begin
      imm_status = STAT_OK;
      imm_fill   = fill_ff;
      needs_tree = 1'b0;
      case (mode)
         MODE_INSERT: begin
            if (full) begin
               imm_status = STAT_FULL;
            end else if (!ins_ok) begin
               imm_status = STAT_BADPOS;
            end else begin
               imm_fill = fill_ff + CNT_W'(1);
            end
         end
         MODE_DELETE: begin
            if (empty) begin
               imm_status = STAT_EMPTY;
            end else if (!rd_ok) begin
               imm_status = STAT_BADPOS;
            end else begin
               imm_fill = fill_ff - CNT_W'(1);
            end
         end
         MODE_SEARCH: begin
            if (empty) begin
               imm_status = STAT_EMPTY;
            end else begin
               needs_tree = 1'b1;
            end
         end
         MODE_READ: begin
            if (empty) begin
               imm_status = STAT_EMPTY;
            end else if (!rd_ok) begin
               imm_status = STAT_BADPOS;
            end else begin
               needs_tree = 1'b1;
            end
         end
         MODE_CLEAR: begin
            imm_fill = '0;
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && needs_tree) begin
               state_in = S_TREE;
            end
         end
         S_TREE: begin
            if (tcnt_ff == ONE_CNT) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // outputs of the controller
   always_comb begin
      req_stall = 1'b1;
      load_tree = 1'b0;
      tcnt_in   = tcnt_ff;
      case (state_ff)
         S_IDLE: begin
            req_stall = !rsp_free;
            tcnt_in   = DEPTH_CNT;
         end
         S_TREE: begin
            tcnt_in = tcnt_ff - ONE_CNT;
         end
         S_DONE: begin
            load_tree = rsp_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;
   assign load_imm = accept && !needs_tree;

   assign cmd.ins    = accept && (mode == MODE_INSERT) && ins_ok;
   assign cmd.del    = accept && (mode == MODE_DELETE) && rd_ok;
   assign cmd.search = op_search_ff;
   assign cell_k     = (state_ff == S_IDLE) ? req_k : op_k_ff;

   assign fill_in = load_imm ? imm_fill : fill_ff;

   // cell row
   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      plist_cell #(
         .IDX   (j),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .k           (cell_k),
         .fill        (fill_ff),
         .key         (op_value_ff),
         .new_value   (req_value),
         .left_value  ((j == 0) ? req_value : ent[(j == 0) ? 0 : j-1]),
         .right_value ((j == CAPACITY-1) ? ent[j] : ent[(j == CAPACITY-1) ? j : j+1]),
         .entry       (ent[j]),
         .hit         (nd[LEAVES-1+j].hit)
      );
      assign nd[LEAVES-1+j].value = ent[j];
      assign nidx[LEAVES-1+j]     = IDX_W'(j);
   end

   for (genvar j = CAPACITY; j < LEAVES; j++) begin : g_pad
      assign nd[LEAVES-1+j].hit   = 1'b0;
      assign nd[LEAVES-1+j].value = '0;
      assign nidx[LEAVES-1+j]     = IDX_W'(j);
   end

   // first-hit tree
   for (genvar n = 0; n < LEAVES-1; n++) begin : g_node
      plist_merge #(
         .IDX_W (IDX_W)
      ) u_merge (
         .clock      (clock),
         .left_node  (nd[2*n+1]),
         .left_idx   (nidx[2*n+1]),
         .right_node (nd[2*n+2]),
         .right_idx  (nidx[2*n+2]),
         .out_node   (nd[n]),
         .out_idx    (nidx[n])
      );
   end

   assign root_pos = {1'b0, nidx[0]} + {{IDX_W{1'b0}}, 1'b1};

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      found_in     = found_ff;
      read_in      = read_ff;
      count_in     = count_ff;
      if (load_imm) begin
         rsp_valid_in = 1'b1;
         status_in    = imm_status;
         found_in     = '0;
         read_in      = '0;
         count_in     = POS_W'(imm_fill);
      end else if (load_tree) begin
         rsp_valid_in = 1'b1;
         count_in     = POS_W'(fill_ff);
         if (op_search_ff) begin
            status_in = nd[0].hit ? STAT_OK : STAT_NOTFOUND;
            found_in  = nd[0].hit ? POS_W'(root_pos) : '0;
            read_in   = '0;
         end else begin
            status_in = STAT_OK;
            found_in  = '0;
            read_in   = nd[0].value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tcnt_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tcnt_ff      <= tcnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
      read_ff   <= read_in;
      count_ff  <= count_in;
      if (accept) begin
         op_search_ff <= mode == MODE_SEARCH;
         op_k_ff      <= req_k;
         op_value_ff  <= req_value;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_read_value     = read_ff;
   assign rsp_entry_count    = count_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CAP_CNT)
      else $error("fill count above capacity");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("transfer accepted while busy");

   a_tree_holds_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TREE |=> $stable(fill_ff))
      else $error("list changed during tree walk");

   a_found_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (found_ff != '0) |-> status_ff == STAT_OK)
      else $error("found position without ok status");

endmodule

@@ dv/list_checker.sv @@
// Checker for the positional list engine: tracks the list contents and checks every result.
`timescale 1ns / 1ps
module list_checker
   import plist_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [STATUS_W-1:0]       rsp_status,
   input  logic [POS_W-1:0]          rsp_found_position,
   input  logic signed [VALUE_W-1:0] rsp_read_value,
   input  logic [POS_W-1:0]          rsp_entry_count,
   input  logic                      end_check,
   output int unsigned               fail_count
);

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [POS_W-1:0]          found;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          count;
   } list_answer_type;

   logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
   int unsigned               shadow_fill;
   list_answer_type           answers_due [$];
   logic                      end_seen;

   task automatic report_mismatch(input string msg);
      if (fail_count < 100)
         $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   // Applies one operation to the shadow list and returns the answer it should give.
   function automatic list_answer_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VALUE_W-1:0] val);
      list_answer_type ans;
      int              i;
      ans.status = STAT_OK;
      ans.found  = '0;
      ans.value  = '0;
      case (mode)
         MODE_INSERT: begin
            if (shadow_fill >= CAPACITY)
               ans.status = STAT_FULL;
            else if (pos == 0 || pos > shadow_fill + 1)
               ans.status = STAT_BADPOS;
            else begin
               for (i = shadow_fill; i >= pos; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[pos-1] = val;
               shadow_fill++;
            end
         end
         MODE_DELETE: begin
            if (shadow_fill == 0)
               ans.status = STAT_EMPTY;
            else if (pos == 0 || pos > shadow_fill)
               ans.status = STAT_BADPOS;
            else begin
               for (i = pos - 1; i + 1 < shadow_fill; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_fill--;
            end
         end
         MODE_SEARCH: begin
            if (shadow_fill == 0)
               ans.status = STAT_EMPTY;
            else begin
               ans.status = STAT_NOTFOUND;
               for (i = 0; i < shadow_fill; i++) begin
                  if (shadow_list[i] == val) begin
                     ans.status = STAT_OK;
                     ans.found  = POS_W'(i + 1);
                     break;
                  end
               end
            end
         end
         MODE_READ: begin
            if (shadow_fill == 0)
               ans.status = STAT_EMPTY;
            else if (pos == 0 || pos > shadow_fill)
               ans.status = STAT_BADPOS;
            else
               ans.value = shadow_list[pos-1];
         end
         MODE_CLEAR: shadow_fill = 0;
         default: ;
      endcase
      ans.count = POS_W'(shadow_fill);
      return ans;
   endfunction

   always @(posedge clock) begin
      list_answer_type due;
      if (reset) begin
         shadow_fill = 0;
         answers_due.delete();
         end_seen = 1'b0;
      end else begin
         if (req_valid && !req_stall)
            answers_due.push_back(apply_list_op(req_mode, req_position, req_value));
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0)
               report_mismatch($sformatf("result with none pending, status %0d", rsp_status));
            else begin
               due = answers_due.pop_front();
               if (rsp_status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, due.status));
               if (rsp_found_position !== due.found)
                  report_mismatch($sformatf("found_position %0d, expected %0d",
                                            rsp_found_position, due.found));
               if (rsp_read_value !== due.value)
                  report_mismatch($sformatf("read_value %0d, expected %0d",
                                            rsp_read_value, due.value));
               if (rsp_entry_count !== due.count)
                  report_mismatch($sformatf("entry_count %0d, expected %0d",
                                            rsp_entry_count, due.count));
            end
         end
         if (end_check && !end_seen) begin
            end_seen = 1'b1;
            while (answers_due.size() != 0) begin
               due = answers_due.pop_front();
               report_mismatch($sformatf("result never arrived, expected status %0d count %0d",
                                         due.status, due.count));
            end
         end
      end
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the positional list engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import plist_pkg::*;

   localparam int CAPACITY     = DEF_CAPACITY;
   localparam int RANDOM_OPS   = 1100;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic [POS_W-1:0]          rsp_found_position;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [POS_W-1:0]          rsp_entry_count;
   logic                      end_check;
   int unsigned               fail_count;

   int unsigned ops_sent     = 0;
   int unsigned results_seen = 0;
   int unsigned cycle_count  = 0;
   int unsigned list_fill    = 0;
   int unsigned creates_done = 0;
   int unsigned holds_done   = 0;
   bit          calm         = 1'b0;
   bit          hold_asked   = 1'b0;

   logic signed [VALUE_W-1:0] value_pool [12] = '{
      32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
      32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd100,
      -32'sd100, 32'sd42, 32'sh0000_ffff, 32'shffff_0000
   };

   always #5 clock = ~clock;

   positional_list_engine dut (.*);

   list_checker #(.CAPACITY(CAPACITY)) list_check (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (reset === 1'b0 && rsp_valid && !rsp_stall)
         results_seen++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(1, 0))
         return value_pool[$urandom_range(11, 0)];
      return $urandom;
   endfunction

   // One transfer on the request side; keeps a rough fill count to aim positions.
   task automatic send_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic signed [VALUE_W-1:0] val);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(9, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall);
      ops_sent++;
      case (mode)
         MODE_INSERT:
            if (list_fill < CAPACITY && pos != 0 && pos <= list_fill + 1)
               list_fill++;
         MODE_DELETE:
            if (pos != 0 && pos <= list_fill)
               list_fill--;
         MODE_CLEAR: list_fill = 0;
         default: ;
      endcase
   endtask

   task automatic random_op();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 30)
         send_op(MODE_INSERT, POS_W'($urandom_range(list_fill + 1, 1)), pick_value());
      else if (roll < 45)
         send_op(MODE_DELETE, POS_W'($urandom_range(list_fill, 1)), $urandom);
      else if (roll < 60)
         send_op(MODE_SEARCH, POS_W'($urandom), pick_value());
      else if (roll < 75)
         send_op(MODE_READ, POS_W'($urandom_range(list_fill, 1)), $urandom);
      else if (roll < 78)
         send_op(MODE_CLEAR, POS_W'($urandom), $urandom);
      else if (roll < 95)
         send_op(MODE_W'($urandom_range(MODE_CLEAR, MODE_INSERT)), POS_W'($urandom),
                 pick_value());
      else
         send_op(MODE_W'($urandom_range((1 << MODE_W) - 1, MODE_CLEAR + 1)),
                 POS_W'($urandom), $urandom);
   endtask

   // Bulk create: clear, then append; past capacity the appends come back full.
   task automatic create_list(input int unsigned n);
      send_op(MODE_CLEAR, POS_W'($urandom), $urandom);
      repeat (n) send_op(MODE_INSERT, POS_W'(list_fill + 1), pick_value());
      creates_done++;
   endtask

   initial begin : result_sink
      int unsigned gap;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            gap = calm ? 0 : $urandom_range(9, 0);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      int unsigned op_target;
      int unsigned round;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_mode     <= MODE_INSERT;
      req_position <= '0;
      req_value    <= '0;
      end_check    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list, bad positions, front / middle / end inserts, duplicates
      send_op(MODE_READ, 7'd1, 32'sd0);
      send_op(MODE_SEARCH, 7'd0, 32'sd100);
      send_op(MODE_DELETE, 7'd1, 32'sd0);
      send_op(MODE_INSERT, 7'd0, 32'sd5);
      send_op(MODE_INSERT, 7'd2, 32'sd5);
      send_op(MODE_INSERT, 7'd1, 32'sh8000_0000);
      send_op(MODE_INSERT, 7'd2, 32'sh7fff_ffff);
      send_op(MODE_INSERT, 7'd1, 32'sd0);
      send_op(MODE_INSERT, 7'd3, -32'sd1);
      send_op(MODE_INSERT, 7'd5, 32'sd0);
      send_op(MODE_SEARCH, 7'd127, 32'sd0);
      send_op(MODE_SEARCH, 7'd0, 32'sh7fff_ffff);
      send_op(MODE_SEARCH, 7'd0, 32'sd777);
      send_op(MODE_READ, 7'd2, 32'sd0);
      send_op(MODE_READ, 7'd4, 32'sd0);
      send_op(MODE_READ, 7'd0, 32'sd0);
      send_op(MODE_READ, 7'd6, 32'sd0);
      send_op(MODE_DELETE, 7'd127, 32'sd0);
      send_op(MODE_DELETE, 7'd3, 32'sd0);
      send_op(MODE_READ, 7'd3, 32'sd0);
      send_op(MODE_DELETE, 7'd4, 32'sd0);
      send_op(MODE_W'(MODE_CLEAR + 3), 7'h7f, 32'shffff_ffff);
      send_op(MODE_CLEAR, 7'd0, 32'sd0);
      send_op(MODE_READ, 7'd1, 32'sd0);
      send_op(MODE_INSERT, 7'd127, 32'sd1);

      op_target = ops_sent + RANDOM_OPS;
      round     = 0;
      while (ops_sent < op_target) begin
         calm = ($urandom_range(3, 0) == 0);
         if (round % 3 == 0)
            create_list(($urandom_range(2, 0) == 0) ? CAPACITY + $urandom_range(2, 0)
                                                    : $urandom_range(20, 1));
         repeat ($urandom_range(40, 10)) random_op();
         if (round == 3 || round == 17) begin
            // output held off while requests keep coming
            hold_asked = 1'b1;
            calm       = 1'b1;
            repeat (40) random_op();
            holds_done++;
         end
         if (round % 5 == 4) begin
            req_valid <= 1'b0;
            wait (results_seen == ops_sent);
         end
         round++;
      end

      req_valid <= 1'b0;
      wait (results_seen == ops_sent);
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Summary: %0d list operations sent, %0d results compared, %0d failures",
               ops_sent, results_seen, fail_count);
      $display("Covered %0d bulk creates (some past capacity) and %0d long output holds",
               creates_done, holds_done);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
hdl/plist_pkg.sv
hdl/plist_cell.sv
hdl/plist_merge.sv
hdl/positional_list_engine.sv
dv/list_checker.sv
dv/tb_top.sv
